[sv/bqc_pkg.sv]
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared constants, control type and saturation helper for the biquad core.
// ----------------------------------------------------------------------------
package bqc_pkg;

    localparam int MAX_BIQUADS        = 16;
    localparam int COEFS_PER_SECTION  = 7;
    localparam int DELAYS_PER_SECTION = 4;

    localparam int ACC_W    = 67;
    localparam int Y_SHIFT  = 30;
    localparam int GAIN_FRAC = 14;
    localparam int SAT_W    = 72;

    localparam logic signed [ACC_W-1:0] ROUND_Y = ACC_W'(64'sd1 <<< 29);

    typedef struct packed {
        logic ld_shift;
        logic ld_gain;
        logic mul_gain;
        logic prod_en;
        logic acc_clr;
        logic acc_en;
        logic y_en;
        logic v_en;
    } t_mac_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic fits;
        fits = (v[SAT_W-1:31] == '0) || (v[SAT_W-1:31] == '1);
        if (fits) begin
            return v[31:0];
        end else if (v[SAT_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

endpackage

[sv/bqc_ram.sv]
// ----------------------------------------------------------------------------
// bqc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bqc_mac.sv]
// ----------------------------------------------------------------------------
// bqc_mac
// Shared 32x32 multiplier, five-term accumulator, Q2.30 rounding to y and
// gain scaling with rounded variable shift; both results saturated.
// ----------------------------------------------------------------------------
module bqc_mac (
    input  logic               i_clk,
    input  bqc_pkg::t_mac_ctl  i_ctl,
    input  logic signed [31:0] i_coef,
    input  logic signed [31:0] i_opnd,
    output logic signed [31:0] o_y,
    output logic signed [31:0] o_v
);

    import bqc_pkg::*;

    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0]      r_y;
    logic signed [31:0]      r_v;
    logic [4:0]              r_shift;
    logic signed [31:0]      r_gain;

    logic signed [31:0]      mul_a;
    logic signed [31:0]      mul_b;
    logic signed [63:0]      n_prod;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [ACC_W-1:0] acc_sh;
    logic [4:0]              n_shift;
    logic [5:0]              sb;
    logic signed [64:0]      rnd;
    logic signed [64:0]      scaled;

    assign mul_a  = i_ctl.mul_gain ? r_gain : i_coef;
    assign mul_b  = i_ctl.mul_gain ? r_y    : i_opnd;
    assign n_prod = mul_a * mul_b;

    assign acc_rnd = r_acc + ROUND_Y;
    assign acc_sh  = acc_rnd >>> Y_SHIFT;

    always_comb begin
        if (i_coef[31]) begin
            n_shift = 5'd0;
        end else if (i_coef > 32'sd31) begin
            n_shift = 5'd31;
        end else begin
            n_shift = i_coef[4:0];
        end
    end

    assign sb     = 6'(GAIN_FRAC) + {1'b0, r_shift};
    assign rnd    = $signed(65'd1 << (sb - 6'd1));
    assign scaled = (65'(r_prod) + rnd) >>> sb;

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= n_prod;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.y_en) begin
            r_y <= sat32(SAT_W'(acc_sh));
        end
        if (i_ctl.v_en) begin
            r_v <= sat32(SAT_W'(scaled));
        end
        if (i_ctl.ld_shift) begin
            r_shift <= n_shift;
        end
        if (i_ctl.ld_gain) begin
            r_gain <= i_coef;
        end
    end

    assign o_y = r_y;
    assign o_v = r_v;

endmodule

[sv/biquad_cascade_iir_df1_core.sv]
// ----------------------------------------------------------------------------
// biquad_cascade_iir_df1_core
// Cascaded direct form 1 biquad filter, Q1.31 samples, parallel branches of
// series sections summed and saturated; coefficients and delays in RAM.
//
//  channel    | dir | transfer                 | payload
//  s_axis     | in  | tvalid & tready          | tuser: req_type; tdata: sample,
//             |     |                          |   coef_index, coef_value
//  m_axis     | out | tvalid & tready          | tdata: filtered
//  apb        | in  | psel&penable&pwrite      | 0x0 num_biquads, 0x4 series_length
//
// A coefficient write is taken while idle. A sample runs through the N sections
// in use in turn (straight out with none): one shared multiplier and one read
// port per RAM walk the seven coefficient and four delay words of each section.
// Reset clears the per-section delay valid flags at once; no clearing pass.
// A result waits in the output register while the next transfer is taken;
// only a finished sample with the output register still full stalls.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_df1_core #(
    parameter int MAX_BIQUADS = bqc_pkg::MAX_BIQUADS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // sample[31:0], coef_index[38:32], coef_value[70:39]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // filtered[31:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import bqc_pkg::*;

    localparam int COEF_DEPTH  = MAX_BIQUADS * COEFS_PER_SECTION;
    localparam int DELAY_DEPTH = MAX_BIQUADS * DELAYS_PER_SECTION;
    localparam int CA_W  = $clog2(COEF_DEPTH);
    localparam int DA_W  = $clog2(DELAY_DEPTH);
    localparam int SEC_W = (MAX_BIQUADS > 1) ? $clog2(MAX_BIQUADS) : 1;
    localparam int CNT_W = $clog2(MAX_BIQUADS + 1);
    localparam int TOT_W = 33 + CNT_W;

    localparam logic REQ_COEF = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_Y    = 6'b000100,
        S_WB   = 6'b001000,
        S_NEXT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [4:0]              r_num;
    logic [4:0]              r_ser;
    logic [2:0]              r_k;
    logic [CNT_W-1:0]        r_sec;
    logic [4:0]              r_pos;
    logic [CA_W-1:0]         r_cbase;
    logic [DA_W-1:0]         r_dbase;
    logic signed [31:0]      r_x;
    logic signed [31:0]      r_in;
    logic signed [31:0]      r_dly [4];
    logic signed [TOT_W-1:0] r_total;
    logic [MAX_BIQUADS-1:0]  r_dvalid;
    logic                    r_mvalid;
    logic [31:0]             r_mdata;

    logic                    in_xfer;
    logic                    cfg_wr;
    logic signed [31:0]      in_sample;
    logic [6:0]              in_cidx;
    logic signed [31:0]      in_cval;
    logic [6:0]              nb7;
    logic [CNT_W-1:0]        n_eff;
    logic [4:0]              ns_eff;
    logic                    sec_last;
    logic                    br_end;
    logic                    out_load;

    logic                    coef_we;
    logic                    coef_re;
    logic [CA_W-1:0]         coef_raddr;
    logic [31:0]             coef_rd;
    logic                    dly_we;
    logic                    dly_re;
    logic [DA_W-1:0]         dly_addr;
    logic [31:0]             dly_wdata;
    logic [31:0]             dly_rd;
    logic signed [31:0]      dly_masked;
    logic signed [31:0]      opnd;
    logic [1:0]              dly_idx;
    t_mac_ctl                mac_ctl;
    logic signed [31:0]      mac_y;
    logic signed [31:0]      mac_v;

    assign in_sample = s_axis_tdata[31:0];
    assign in_cidx   = s_axis_tdata[38:32];
    assign in_cval   = s_axis_tdata[70:39];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'(r_ser) : 32'(r_num);

    assign nb7    = 7'(r_num);
    assign n_eff  = (nb7 > 7'(MAX_BIQUADS)) ? CNT_W'(MAX_BIQUADS) : CNT_W'(nb7);
    assign ns_eff = (r_ser == 5'd0) ? 5'd1 : r_ser;

    assign sec_last = ((r_sec + CNT_W'(1)) == n_eff);
    assign br_end   = sec_last || (r_pos == ns_eff - 5'd1);
    assign out_load = (r_state == S_OUT) && (!r_mvalid || m_axis_tready);

    // memory ports
    assign coef_we    = in_xfer && (s_axis_tuser == REQ_COEF)
                        && (32'(in_cidx) < 32'(COEF_DEPTH));
    assign coef_re    = (r_state == S_READ) && (r_k <= 3'd6);
    assign coef_raddr = r_cbase + CA_W'(r_k);

    assign dly_re   = (r_state == S_READ) && (r_k <= 3'd3);
    assign dly_we   = (r_state == S_WB);
    assign dly_addr = r_dbase + DA_W'(r_k[1:0]);

    always_comb begin
        case (r_k[1:0])
            2'd0:    dly_wdata = r_dly[1];
            2'd1:    dly_wdata = mac_y;
            2'd2:    dly_wdata = r_dly[3];
            default: dly_wdata = r_in;
        endcase
    end

    assign dly_masked = r_dvalid[r_sec[SEC_W-1:0]] ? $signed(dly_rd) : 32'sd0;
    assign opnd       = (r_k <= 3'd4) ? dly_masked : r_in;
    assign dly_idx    = 2'(r_k - 3'd1);

    bqc_ram #(
        .WIDTH (32),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (CA_W'(in_cidx)),
        .i_wdata (in_cval),
        .i_re    (coef_re),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rd)
    );

    bqc_ram #(
        .WIDTH (32),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (dly_addr),
        .i_wdata (dly_wdata),
        .i_re    (dly_re),
        .i_raddr (dly_addr),
        .o_rdata (dly_rd)
    );

    // datapath control
    always_comb begin
        mac_ctl          = '0;
        mac_ctl.acc_clr  = (r_state == S_READ) && (r_k == 3'd0);
        mac_ctl.prod_en  = ((r_state == S_READ) && (r_k >= 3'd1) && (r_k <= 3'd5))
                           || ((r_state == S_WB) && (r_k == 3'd0));
        mac_ctl.mul_gain = (r_state == S_WB);
        mac_ctl.acc_en   = (r_state == S_READ) && (r_k >= 3'd2) && (r_k <= 3'd6);
        mac_ctl.ld_shift = (r_state == S_READ) && (r_k == 3'd6);
        mac_ctl.ld_gain  = (r_state == S_READ) && (r_k == 3'd7);
        mac_ctl.y_en     = (r_state == S_Y);
        mac_ctl.v_en     = (r_state == S_WB) && (r_k == 3'd1);
    end

    bqc_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_coef (coef_rd),
        .i_opnd (opnd),
        .o_y    (mac_y),
        .o_v    (mac_v)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (s_axis_tuser != REQ_COEF)) begin
                    n_state = (n_eff == '0) ? S_OUT : S_READ;
                end
            end
            S_READ: begin
                if (r_k == 3'd7) begin
                    n_state = S_Y;
                end
            end
            S_Y: begin
                n_state = S_WB;
            end
            S_WB: begin
                if (r_k == 3'd3) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_state = sec_last ? S_OUT : S_READ;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_num    <= 5'd0;
            r_ser    <= 5'd1;
            r_dvalid <= '0;
            r_mvalid <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && pready) begin
                if (paddr[2]) begin
                    r_ser <= pwdata[4:0];
                end else begin
                    r_num <= pwdata[4:0];
                end
            end
            if ((r_state == S_WB) && (r_k == 3'd3)) begin
                r_dvalid[r_sec[SEC_W-1:0]] <= 1'b1;
            end
            if (out_load) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            if ((r_state == S_READ && r_k == 3'd7) || (r_state == S_WB && r_k == 3'd3)
                || (r_state == S_IDLE) || (r_state == S_Y) || (r_state == S_NEXT)) begin
                r_k <= '0;
            end else begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && (s_axis_tuser != REQ_COEF)) begin
            r_x     <= in_sample;
            r_in    <= in_sample;
            r_sec   <= '0;
            r_pos   <= '0;
            r_cbase <= '0;
            r_dbase <= '0;
            r_total <= (n_eff == '0) ? TOT_W'(in_sample) : '0;
        end
        if ((r_state == S_READ) && (r_k >= 3'd1) && (r_k <= 3'd4)) begin
            r_dly[dly_idx] <= dly_masked;
        end
        if (r_state == S_NEXT) begin
            r_sec   <= r_sec + CNT_W'(1);
            r_cbase <= r_cbase + CA_W'(COEFS_PER_SECTION);
            r_dbase <= r_dbase + DA_W'(DELAYS_PER_SECTION);
            if (br_end) begin
                r_total <= r_total + TOT_W'(mac_v);
                r_in    <= r_x;
                r_pos   <= '0;
            end else begin
                r_in    <= mac_v;
                r_pos   <= r_pos + 5'd1;
            end
        end
        if (out_load) begin
            r_mdata <= sat32(SAT_W'(r_total));
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for biquad_cascade_iir_df1_core. Coefficient words and
// samples go in over the input stream; every filtered sample that comes back
// is checked against a bit-exact predictor of the cascade kept here. The run
// starts with passthrough, loads every coefficient word, goes through full
// scale and out-of-range shift cases, out-of-range coefficient indices and
// the section layouts, then runs random traffic under changing register
// settings with random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

    import bqc_pkg::*;

    localparam int COEF_WORDS  = MAX_BIQUADS * COEFS_PER_SECTION;
    localparam int DELAY_WORDS = MAX_BIQUADS * DELAYS_PER_SECTION;
    localparam int SETTLE_CYCLES = 2 + 14 * MAX_BIQUADS + 24;
    localparam int RANDOM_ITEMS  = 450;

    localparam bit REQ_FILTER = 1'b0;
    localparam bit REQ_COEF   = 1'b1;

    localparam logic [2:0] ADDR_NUM_BIQUADS   = 3'h0;
    localparam logic [2:0] ADDR_SERIES_LENGTH = 3'h4;

    localparam int TAP_A2     = 0;
    localparam int TAP_A1     = 1;
    localparam int TAP_B2     = 2;
    localparam int TAP_B1     = 3;
    localparam int TAP_B0     = 4;
    localparam int WORD_SHIFT = 5;
    localparam int WORD_GAIN  = 6;

    localparam logic signed [31:0] Q31_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // sample[31:0], coef_index[38:32], coef_value[70:39]
    logic        s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // filtered[31:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    biquad_cascade_iir_df1_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    logic signed [31:0] coef_mem  [COEF_WORDS];
    logic signed [31:0] delay_mem [DELAY_WORDS];
    logic [4:0]         cfg_sections;
    logic [4:0]         cfg_series;
    logic [31:0]        expected_filtered [$];
    logic [31:0]        want_filtered;

    int send_gap_max = 15;
    int stall_max    = 15;
    int n_fail;
    int n_results;
    int n_samples;
    int n_coef_writes;
    int n_settings;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #10_000_000;
        $display("Timeout: %0d results still outstanding", expected_filtered.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic signed [31:0] saturate_q31(input logic signed [71:0] v);
        if (v > 72'sd2147483647) begin
            return Q31_MAX;
        end else if (v < -72'sd2147483648) begin
            return Q31_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] section_response(input int s,
                                                            input logic signed [31:0] x);
        int                 c;
        int                 d;
        int                 sb;
        logic signed [71:0] acc;
        logic signed [71:0] scaled;
        logic signed [31:0] y;
        logic signed [31:0] sh;
        c = s * COEFS_PER_SECTION;
        d = s * DELAYS_PER_SECTION;
        acc = coef_mem[c + TAP_A2] * delay_mem[d] + coef_mem[c + TAP_A1] * delay_mem[d + 1]
            + coef_mem[c + TAP_B2] * delay_mem[d + 2] + coef_mem[c + TAP_B1] * delay_mem[d + 3]
            + coef_mem[c + TAP_B0] * x;
        acc = (acc + (72'sd1 <<< 29)) >>> 30;
        y = saturate_q31(acc);
        delay_mem[d]     = delay_mem[d + 1];
        delay_mem[d + 1] = y;
        delay_mem[d + 2] = delay_mem[d + 3];
        delay_mem[d + 3] = x;
        sh = coef_mem[c + WORD_SHIFT];
        if (sh < 0) sh = 0;
        if (sh > 31) sh = 31;
        sb = 14 + sh;
        scaled = coef_mem[c + WORD_GAIN] * y;
        scaled = (scaled + (72'sd1 <<< (sb - 1))) >>> sb;
        return saturate_q31(scaled);
    endfunction

    function automatic logic signed [31:0] predict_filtered(input logic signed [31:0] x);
        int                 n;
        int                 ns;
        logic signed [71:0] total;
        logic signed [31:0] v;
        n = (cfg_sections > MAX_BIQUADS) ? MAX_BIQUADS : cfg_sections;
        ns = (cfg_series == 0) ? 1 : cfg_series;
        if (n == 0) return x;
        total = '0;
        for (int j = 0; j < n; j += ns) begin
            v = x;
            for (int s = j; s < j + ns && s < n; s++) begin
                v = section_response(s, v);
            end
            total += v;
        end
        return saturate_q31(total);
    endfunction

    function automatic int draw_gap(input int max_gap);
        if (max_gap == 0 || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, max_gap);
    endfunction

    function automatic logic [31:0] draw_sample();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: return Q31_MIN;
                1: return Q31_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // well-behaved words keep |a1|+|a2| below one and the gain near unity
    function automatic logic [31:0] draw_coef_word(input int slot, input bit wild);
        if (wild) begin
            if (slot == WORD_SHIFT && $urandom_range(0, 1)) return $urandom_range(0, 40);
            return $urandom;
        end
        case (slot)
            WORD_SHIFT: return $urandom_range(0, 1);
            WORD_GAIN:  return $urandom_range(12000, 20000);
            TAP_B0:     return $urandom_range(0, 32'h3fff_ffff) - 32'h2000_0000;
            default:    return $urandom_range(0, 32'h1fff_ffff) - 32'h1000_0000;
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        n_fail++;
        if (n_fail <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (expected_filtered.size() == 0) begin
                note_failure($sformatf("result %h with nothing outstanding", m_axis_tdata));
            end else begin
                want_filtered = expected_filtered.pop_front();
                if (m_axis_tdata !== want_filtered) begin
                    note_failure($sformatf("result %0d: expected %h, got %h",
                                           n_results, want_filtered, m_axis_tdata));
                end
            end
        end
    end

    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(stall_max);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_item(input bit req, input logic [31:0] smp, input logic [6:0] idx,
                             input logic [31:0] val);
        int gap;
        gap = draw_gap(send_gap_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {1'b0, val, idx, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (req == REQ_COEF) begin
            if (idx < COEF_WORDS) begin
                coef_mem[idx] = val;
                n_coef_writes++;
            end
        end else begin
            expected_filtered.push_back(predict_filtered(smp));
            n_samples++;
        end
    endtask

    task automatic filter_sample(input logic [31:0] smp);
        send_item(REQ_FILTER, smp, 7'($urandom), $urandom);
    endtask

    task automatic write_coef(input int idx, input logic [31:0] val);
        send_item(REQ_COEF, $urandom, 7'(idx), val);
    endtask

    task automatic load_section(input int s, input bit wild);
        for (int k = 0; k < COEFS_PER_SECTION; k++) begin
            write_coef(s * COEFS_PER_SECTION + k, draw_coef_word(k, wild));
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_filtered.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [4:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {27'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_NUM_BIQUADS) cfg_sections = value;
        else cfg_series = value;
    endtask

    task automatic set_layout(input logic [4:0] sections, input logic [4:0] series);
        wait_idle();
        write_reg(ADDR_NUM_BIQUADS, sections);
        write_reg(ADDR_SERIES_LENGTH, series);
        n_settings++;
    endtask

    task automatic test_passthrough();
        set_layout(5'd0, 5'd1);
        filter_sample(Q31_MIN);
        filter_sample(Q31_MAX);
        filter_sample('0);
        filter_sample('1);
        filter_sample(32'h0000_0001);
    endtask

    task automatic test_load_coefficients();
        for (int s = 0; s < MAX_BIQUADS; s++) load_section(s, 1'b0);
    endtask

    // five full-scale products push the sum well past 64 bits
    task automatic test_accumulator_range();
        set_layout(5'd1, 5'd1);
        for (int k = TAP_A2; k <= TAP_B0; k++) write_coef(k, Q31_MIN);
        write_coef(WORD_SHIFT, 32'd0);
        write_coef(WORD_GAIN, Q31_MAX);
        repeat (3) filter_sample(Q31_MIN);
        write_coef(WORD_GAIN, Q31_MIN);
        filter_sample(Q31_MAX);
        filter_sample(Q31_MIN);
        load_section(0, 1'b0);
    endtask

    task automatic test_shift_range();
        set_layout(5'd1, 5'd1);
        write_coef(WORD_GAIN, Q31_MAX);
        write_coef(WORD_SHIFT, 32'hffff_ffff);
        filter_sample($urandom);
        write_coef(WORD_SHIFT, 32'd31);
        filter_sample(Q31_MAX);
        write_coef(WORD_SHIFT, 32'd32);
        filter_sample(Q31_MIN);
        write_coef(WORD_SHIFT, 32'h8000_0000);
        filter_sample($urandom);
        load_section(0, 1'b0);
    endtask

    task automatic test_index_out_of_range();
        write_coef(COEF_WORDS, $urandom);
        write_coef(127, 32'hffff_ffff);
        filter_sample($urandom);
    endtask

    // too many sections, zero series length, ragged last branch, long chains
    task automatic test_section_layouts();
        set_layout(5'd16, 5'd16);
        filter_sample(Q31_MAX);
        set_layout(5'd31, 5'd0);
        filter_sample(Q31_MIN);
        set_layout(5'd17, 5'd31);
        filter_sample($urandom);
        set_layout(5'd5, 5'd2);
        filter_sample($urandom);
        filter_sample($urandom);
        set_layout(5'd3, 5'd16);
        filter_sample($urandom);
    endtask

    task automatic test_random_traffic();
        int done;
        int pick;
        logic [4:0] sections;
        logic [4:0] series;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            sections = 5'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 8)
                                                     : $urandom_range(9, 31));
            series = 5'(($urandom_range(0, 9) < 6) ? $urandom_range(1, 4)
                                                   : $urandom_range(0, 31));
            set_layout(sections, series);
            case ($urandom_range(0, 3))
                0: begin send_gap_max = 0;  stall_max = 0;  end
                1: begin send_gap_max = 15; stall_max = 15; end
                2: begin send_gap_max = 15; stall_max = 0;  end
                default: begin send_gap_max = 0; stall_max = 15; end
            endcase
            for (int k = 0; k < 50; k++) begin
                pick = $urandom_range(0, 19);
                if (pick < 15) begin
                    filter_sample(draw_sample());
                    done++;
                end else if (pick < 19) begin
                    pick = $urandom_range(0, COEF_WORDS - 1);
                    write_coef(pick, draw_coef_word(pick % COEFS_PER_SECTION,
                                                    $urandom_range(0, 5) == 0));
                    done++;
                end else begin
                    write_coef($urandom_range(COEF_WORDS, 127), $urandom);
                end
            end
        end
    endtask

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= REQ_FILTER;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        foreach (coef_mem[k]) coef_mem[k] = '0;
        foreach (delay_mem[k]) delay_mem[k] = '0;
        cfg_sections = 5'd0;
        cfg_series   = 5'd1;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough();
        test_load_coefficients();
        test_accumulator_range();
        test_shift_range();
        test_index_out_of_range();
        test_section_layouts();
        test_random_traffic();

        wait_idle();
        $display("Checked %0d of %0d filtered samples against %0d coefficient writes",
                 n_results, n_samples, n_coef_writes);
        $display("over %0d register settings, %0d mismatches", n_settings, n_fail);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/bqc_pkg.sv
sv/bqc_ram.sv
sv/bqc_mac.sv
sv/biquad_cascade_iir_df1_core.sv
test/testbench.sv
